### hdl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Types, constants and mod-26 helpers shared by the Hill cipher block.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int MAX_ORDER   = 3;
    localparam int MODULUS     = 26;
    localparam int LETTER_W    = 5;
    localparam int KEY_W       = 45;
    localparam int SUM_W       = 11;   // three products of 25*25 at most
    localparam int PREP_CYCLES = 3;
    localparam int PREP_CNT_W  = 2;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_SIZE    = 2'd0,
        CFG_KEY_ENTRIES = 2'd1,
        CFG_DIRECTION   = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef t_letter [MAX_ORDER-1:0] t_row;
    typedef t_row [MAX_ORDER-1:0] t_mat;
    typedef logic [SUM_W-1:0] t_sum;

    typedef struct packed {
        t_mat mat;   // effective matrix, key or inverse key
        logic bad;   // decrypting with a singular key
        logic busy;  // matrix not settled yet
    } t_key_info;

    // x mod 26 for -2080 <= x <= 2015; reciprocal multiply then one correction
    function automatic t_letter mod26(input logic signed [12:0] x);
        logic signed [13:0] xs;
        logic [11:0]        u;
        logic [18:0]        p;
        logic [7:0]         q;
        logic [13:0]        qm;
        logic signed [13:0] r;
        xs = 14'(x) + 14'sd2080;
        u  = xs[11:0];
        p  = 19'(u) * 19'd79;
        q  = p[18:11];
        qm = 14'(q) * 14'd26;
        r  = signed'({2'b00, u}) - signed'(qm);
        if (r < 0) begin
            r = r + 14'sd26;
        end
        return r[LETTER_W-1:0];
    endfunction

    // (+/-) a*b mod 26, a and b already in 0..25
    function automatic t_letter mul_mod(input t_letter a, input t_letter b, input logic neg);
        logic [9:0]         p;
        logic signed [12:0] x;
        p = 10'(a) * 10'(b);
        x = signed'({3'b000, p});
        if (neg) begin
            x = -x;
        end
        return mod26(x);
    endfunction

    function automatic t_letter reduce_letter(input t_letter a);
        return (a >= t_letter'(MODULUS)) ? a - t_letter'(MODULUS) : a;
    endfunction

    // multiplicative inverse mod 26, zero when none exists
    function automatic t_letter inv26(input t_letter d);
        t_letter r;
        unique case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

### hdl/hcb_in_if.sv
// ----------------------------------------------------------------------------
// hcb_in_if
// Input channel: one block of three letter codes.
// ----------------------------------------------------------------------------
interface hcb_in_if;
    import hcb_pkg::*;
    logic    valid;
    logic    ready;
    t_letter letter_first;
    t_letter letter_second;
    t_letter letter_third;

    modport source (output valid, output letter_first, output letter_second,
                    output letter_third, input ready);
    modport sink   (input valid, input letter_first, input letter_second,
                    input letter_third, output ready);
endinterface

### hdl/hcb_out_if.sv
// ----------------------------------------------------------------------------
// hcb_out_if
// Output channel: transformed letters and the singular-key flag.
// ----------------------------------------------------------------------------
interface hcb_out_if;
    import hcb_pkg::*;
    logic    valid;
    logic    ready;
    t_letter out_first;
    t_letter out_second;
    t_letter out_third;
    logic    key_not_invertible;

    modport source (output valid, output out_first, output out_second,
                    output out_third, output key_not_invertible, input ready);
    modport sink   (input valid, input out_first, input out_second,
                    input out_third, input key_not_invertible, output ready);
endinterface

### hdl/hcb_cfg_if.sv
// ----------------------------------------------------------------------------
// hcb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hcb_cfg_if;
    import hcb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [KEY_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/hcb_key_prep.sv
// ----------------------------------------------------------------------------
// hcb_key_prep
// Config registers and a three-stage pipeline that forms the effective
// matrix: reduced key and cofactors, determinant and inverse, final matrix.
// ----------------------------------------------------------------------------
module hcb_key_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hcb_cfg_if.sink            i_cfg,
    output hcb_pkg::t_key_info o_key
);
    import hcb_pkg::*;

    logic [1:0]            r_key_size;
    logic [KEY_W-1:0]      r_key_entries;
    logic                  r_direction;
    logic [PREP_CNT_W-1:0] r_cnt;

    t_mat    r_k, n_k;
    t_mat    r_cof, n_cof;
    t_letter r_inv, n_inv;
    logic    r_bad, n_bad;
    t_mat    r_mat, n_mat;
    logic    order3;
    logic    wr;

    assign order3    = (r_key_size == 2'(MAX_ORDER));
    assign wr        = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size    <= 2'd2;
            r_key_entries <= KEY_W'(45'd1099512676353);
            r_direction   <= 1'b0;
            r_cnt         <= PREP_CNT_W'(PREP_CYCLES);
        end else begin
            if (wr) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_KEY_SIZE:    r_key_size    <= i_cfg.data[1:0];
                    CFG_KEY_ENTRIES: r_key_entries <= i_cfg.data;
                    CFG_DIRECTION:   r_direction   <= i_cfg.data[0];
                    CFG_UNUSED:      ;
                endcase
                r_cnt <= PREP_CNT_W'(PREP_CYCLES);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // stage 1: reduced entries and signed cofactors mod 26
    always_comb begin
        int a0, a1, b0, b1;
        logic [9:0]         pa, pb;
        logic signed [12:0] d;
        for (int e = 0; e < 9; e++) begin
            n_k[e/3][e%3] = reduce_letter(r_key_entries[5*e +: 5]);
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                a0 = (r == 0) ? 1 : 0;
                a1 = (r == 2) ? 1 : 2;
                b0 = (c == 0) ? 1 : 0;
                b1 = (c == 2) ? 1 : 2;
                pa = 10'(n_k[a0][b0]) * 10'(n_k[a1][b1]);
                pb = 10'(n_k[a0][b1]) * 10'(n_k[a1][b0]);
                d  = signed'({3'b000, pa}) - signed'({3'b000, pb});
                if (((r + c) % 2) == 1) begin
                    d = -d;
                end
                n_cof[r][c] = mod26(d);
            end
        end
    end

    // stage 2: determinant, its inverse and the singular flag (the (2,2) cofactor is the 2x2 determinant)
    always_comb begin
        logic [11:0] s;
        t_letter     det;
        s = 12'(r_k[0][0]) * 12'(r_cof[0][0]) + 12'(r_k[0][1]) * 12'(r_cof[0][1])
          + 12'(r_k[0][2]) * 12'(r_cof[0][2]);
        det   = order3 ? mod26(signed'({1'b0, s})) : r_cof[2][2];
        n_inv = inv26(det);
        n_bad = r_direction && (n_inv == '0);
    end

    // stage 3: key, or inverse times adjugate, zero for a singular key
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_mat[i][j] = '0;
                if (!r_direction) begin
                    if (order3 || (i < 2 && j < 2)) begin
                        n_mat[i][j] = r_k[i][j];
                    end
                end else if (!r_bad) begin
                    if (order3) begin
                        n_mat[i][j] = mul_mod(r_inv, r_cof[j][i], 1'b0);
                    end else if (i < 2 && j < 2) begin
                        // 2x2 adjugate: swap diagonal, negate off-diagonal
                        n_mat[i][j] = mul_mod(r_inv, r_k[(j == 0) ? 1 : 0][(i == 0) ? 1 : 0],
                                              i != j);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_cof <= n_cof;
        r_inv <= n_inv;
        r_bad <= n_bad;
        r_mat <= n_mat;
    end

    assign o_key.mat  = r_mat;
    assign o_key.bad  = r_bad;
    assign o_key.busy = (r_cnt != '0);

endmodule

### hdl/hcb_lane.sv
// ----------------------------------------------------------------------------
// hcb_lane
// One row of the matrix times the letter vector, sum registered.
// ----------------------------------------------------------------------------
module hcb_lane (
    input  logic          i_clk,
    input  logic          i_en,
    input  hcb_pkg::t_row i_row,
    input  hcb_pkg::t_row i_vec,
    output hcb_pkg::t_sum o_sum
);
    import hcb_pkg::*;

    t_sum r_sum, n_sum;

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < MAX_ORDER; j++) begin
            n_sum = n_sum + SUM_W'(i_row[j]) * SUM_W'(i_vec[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

### hdl/hcb_merge.sv
// ----------------------------------------------------------------------------
// hcb_merge
// Reduces the lane sums mod 26 and holds the finished result item.
// ----------------------------------------------------------------------------
module hcb_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  hcb_pkg::t_sum [hcb_pkg::MAX_ORDER-1:0] i_sums,
    input  logic                          i_bad,
    output logic                          o_adv,
    hcb_out_if.source                     o_out
);
    import hcb_pkg::*;

    logic r_valid;
    t_row r_res;
    logic r_bad;

    assign o_adv = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_res[i] <= mod26(signed'({2'b00, i_sums[i]}));
            end
            r_bad <= i_bad;
        end
    end

    assign o_out.valid              = r_valid;
    assign o_out.out_first          = r_res[0];
    assign o_out.out_second         = r_res[1];
    assign o_out.out_third          = r_res[2];
    assign o_out.key_not_invertible = r_bad;

endmodule

### hdl/hill_cipher_block_unit.sv
// ----------------------------------------------------------------------------
// hill_cipher_block_unit
// Hill cipher mod 26 with a 2x2 or 3x3 key, one block per cycle when not stalled.
// ----------------------------------------------------------------------------
// One block is taken every cycle while the output drains and the key is
// settled; each result passes letter reduction, three parallel row lanes
// and a mod-26 merge into the output register. After reset and after every
// configuration write the input holds ready low while the key pipeline
// forms the effective matrix (reduced key and cofactors, determinant and
// its inverse, inverse times adjugate). A singular key in decrypt mode
// gives zero letters with key_not_invertible set.
module hill_cipher_block_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcb_in_if.sink    i_in,
    hcb_out_if.source o_out,
    hcb_cfg_if.sink   i_cfg
);
    import hcb_pkg::*;

    t_key_info key;
    logic      r_v1, r_v2;
    t_row      r_vec;
    logic      adv1, adv2, adv3;
    t_sum [MAX_ORDER-1:0] sums;

    hcb_key_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_key   (key)
    );

    assign adv2       = !r_v2 || adv3;
    assign adv1       = !r_v1 || adv2;
    assign i_in.ready = adv1 && !key.busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_in.valid && !key.busy;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_vec[0] <= reduce_letter(i_in.letter_first);
            r_vec[1] <= reduce_letter(i_in.letter_second);
            r_vec[2] <= reduce_letter(i_in.letter_third);
        end
    end

    for (genvar g = 0; g < MAX_ORDER; g++) begin : g_lane
        hcb_lane u_lane (
            .i_clk (i_clk),
            .i_en  (adv2),
            .i_row (key.mat[g]),
            .i_vec (r_vec),
            .o_sum (sums[g])
        );
    end

    hcb_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_sums  (sums),
        .i_bad   (key.bad),
        .o_adv   (adv3),
        .o_out   (o_out)
    );

endmodule

### hdl/hcb_checker.sv
// ----------------------------------------------------------------------------
// hcb_checker
// Port-level checks on the Hill cipher block, bound to the top level.
// ----------------------------------------------------------------------------
module hcb_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input hcb_pkg::t_letter      i_out_first,
    input hcb_pkg::t_letter      i_out_second,
    input hcb_pkg::t_letter      i_out_third,
    input logic                  i_out_bad,
    input logic                  i_cfg_valid,
    input logic                  i_cfg_ready
);
    import hcb_pkg::*;

    // a held result keeps its payload until the transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable(i_out_first) && $stable(i_out_second) && $stable(i_out_third) &&
        $stable(i_out_bad))
        else $error("result changed while stalled");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_first < 5'd26 && i_out_second < 5'd26 &&
        i_out_third < 5'd26)
        else $error("letter out of range");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bad |->
        i_out_first == '0 && i_out_second == '0 && i_out_third == '0)
        else $error("singular key result not zero");

    // new key must settle before the next block
    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_ready |=> !i_in_ready)
        else $error("input taken while key settles");

endmodule

bind hill_cipher_block_unit hcb_checker u_hcb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_first  (o_out.out_first),
    .i_out_second (o_out.out_second),
    .i_out_third  (o_out.out_third),
    .i_out_bad    (o_out.key_not_invertible),
    .i_cfg_valid  (i_cfg.valid),
    .i_cfg_ready  (i_cfg.ready)
);

### sim/hill_cipher_block_unit_test.sv
// ----------------------------------------------------------------------------
// hill_cipher_block_unit_test
// Self-checking bench for the mod-26 Hill cipher block. Letter blocks stream
// in from a queue with random gaps, results are drained with random stalls,
// and every result is checked against a behavioral model of the cipher that
// tracks the key registers. Key order, key entries and direction are swept
// between phases, including singular keys in decrypt mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hill_cipher_block_unit_test;
    import hcb_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_BLOCKS  = 50;

    typedef struct packed {
        t_letter first;
        t_letter second;
        t_letter third;
    } letter_block_t;

    typedef struct packed {
        t_letter first;
        t_letter second;
        t_letter third;
        logic    bad;
    } cipher_result_t;

    logic i_clk;
    logic i_rst_n;

    hcb_in_if  in_ch();
    hcb_out_if out_ch();
    hcb_cfg_if cfg_ch();

    hill_cipher_block_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // shadow copy of the key registers
    logic [1:0]       key_order_reg;
    logic [KEY_W-1:0] key_entries_reg;
    logic             decrypt_reg;

    letter_block_t  pending_blocks[$];
    cipher_result_t expected_cipher[$];
    letter_block_t  block_on_bus;
    bit             block_in_flight;
    bit             pacing_on;
    int             send_gap;
    int             recv_stall;
    int             error_count;
    int             cycle_count;

    function automatic int wrap26(input int x);
        int r;
        r = x % MODULUS;
        return (r < 0) ? r + MODULUS : r;
    endfunction

    function automatic logic [KEY_W-1:0] pack_key(
        input t_letter e0, input t_letter e1, input t_letter e2,
        input t_letter e3, input t_letter e4, input t_letter e5,
        input t_letter e6, input t_letter e7, input t_letter e8);
        return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
    endfunction

    function automatic cipher_result_t hill_transform(input letter_block_t blk);
        int             k[9];
        int             cof[9];
        int             mat[9];
        int             v[3];
        int             res[3];
        int             n, det, inv, minor, s;
        int             r0, r1, c0, c1;
        bit             bad;
        cipher_result_t out;
        n   = (key_order_reg == 2'd3) ? MAX_ORDER : 2;
        inv = -1;
        bad = 1'b0;
        for (int i = 0; i < 9; i++) begin
            k[i]   = int'(key_entries_reg[5*i +: 5]) % MODULUS;
            mat[i] = 0;
        end
        v[0] = int'(blk.first) % MODULUS;
        v[1] = int'(blk.second) % MODULUS;
        v[2] = int'(blk.third) % MODULUS;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r0 = (r == 0) ? 1 : 0;
                r1 = (r == 2) ? 1 : 2;
                c0 = (c == 0) ? 1 : 0;
                c1 = (c == 2) ? 1 : 2;
                minor = k[r0*3+c0] * k[r1*3+c1] - k[r0*3+c1] * k[r1*3+c0];
                cof[r*3+c] = ((r + c) % 2 == 1) ? -minor : minor;
            end
        end
        if (!decrypt_reg) begin
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    mat[i*3+j] = k[i*3+j];
        end else begin
            if (n == 2)
                det = k[0] * k[4] - k[1] * k[3];
            else
                det = k[0] * cof[0] + k[1] * cof[1] + k[2] * cof[2];
            det = wrap26(det);
            for (int i = 1; i < MODULUS; i++) begin
                if (inv < 0 && (det * i) % MODULUS == 1) begin
                    inv = i;
                end
            end
            if (inv < 0) begin
                bad = 1'b1;
            end else if (n == 2) begin
                mat[0] = wrap26(inv * k[4]);
                mat[1] = wrap26(-inv * k[1]);
                mat[3] = wrap26(-inv * k[3]);
                mat[4] = wrap26(inv * k[0]);
            end else begin
                // inverse = det^-1 * transposed cofactors
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        mat[i*3+j] = wrap26(inv * wrap26(cof[j*3+i]));
            end
        end
        for (int i = 0; i < 3; i++) begin
            s = 0;
            if (!bad && i < n) begin
                for (int j = 0; j < n; j++) begin
                    s += mat[i*3+j] * v[j];
                end
            end
            res[i] = wrap26(s);
        end
        out.first  = t_letter'(res[0]);
        out.second = t_letter'(res[1]);
        out.third  = t_letter'(res[2]);
        out.bad    = bad;
        return out;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!pacing_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_letter rand_letter();
        if ($urandom_range(0, 99) < 15) return t_letter'($urandom_range(0, 31));
        return t_letter'($urandom_range(0, 25));
    endfunction

    task automatic queue_block(input t_letter a, input t_letter b, input t_letter c);
        letter_block_t blk;
        blk.first  = a;
        blk.second = b;
        blk.third  = c;
        pending_blocks.push_back(blk);
    endtask

    // waits until every queued block has its result back
    task automatic drain();
        @(posedge i_clk);
        while (pending_blocks.size() > 0 || block_in_flight || expected_cipher.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [KEY_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_KEY_SIZE:    key_order_reg   = value[1:0];
            CFG_KEY_ENTRIES: key_entries_reg = value;
            CFG_DIRECTION:   decrypt_reg     = value[0];
            default: ;
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // block driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            send_gap        = 0;
            block_in_flight = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_cipher.push_back(hill_transform(block_on_bus));
                block_in_flight = 1'b0;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_blocks.size() > 0) begin
                    block_on_bus          = pending_blocks.pop_front();
                    block_in_flight       = 1'b1;
                    in_ch.letter_first  <= block_on_bus.first;
                    in_ch.letter_second <= block_on_bus.second;
                    in_ch.letter_third  <= block_on_bus.third;
                    in_ch.valid         <= 1'b1;
                    send_gap              = pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        cipher_result_t got;
        cipher_result_t want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_stall   = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.first  = out_ch.out_first;
                got.second = out_ch.out_second;
                got.third  = out_ch.out_third;
                got.bad    = out_ch.key_not_invertible;
                if (expected_cipher.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result %0d %0d %0d flag %b",
                                 got.first, got.second, got.third, got.bad);
                end else begin
                    want = expected_cipher.pop_front();
                    if (got != want) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: exp %0d %0d %0d flag %b, got %0d %0d %0d flag %b",
                                     want.first, want.second, want.third, want.bad,
                                     got.first, got.second, got.third, got.bad);
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                recv_stall   = pick_gap();
                out_ch.ready <= (recv_stall == 0);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [KEY_W-1:0] key;
        int               mode;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.letter_first  = '0;
        in_ch.letter_second = '0;
        in_ch.letter_third  = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_KEY_SIZE;
        cfg_ch.data         = '0;
        key_order_reg       = 2'd2;
        key_entries_reg     = 45'd1099512676353;  // 3x3 identity
        decrypt_reg         = 1'b0;
        error_count         = 0;
        pacing_on           = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity key after reset, letters at and above the alphabet
        queue_block(5'd0, 5'd0, 5'd0);
        queue_block(5'd25, 5'd25, 5'd25);
        queue_block(5'd31, 5'd31, 5'd31);
        queue_block(5'd26, 5'd27, 5'd28);
        queue_block(5'd13, 5'd7, 5'd19);
        drain();

        // order three, every entry above 25
        write_register(CFG_KEY_SIZE, 45'd3);
        write_register(CFG_KEY_ENTRIES, {KEY_W{1'b1}});
        queue_block(5'd31, 5'd0, 5'd17);
        queue_block(5'd25, 5'd1, 5'd30);
        drain();

        // same key is singular
        write_register(CFG_DIRECTION, 45'd1);
        queue_block(5'd4, 5'd9, 5'd22);
        queue_block(5'd31, 5'd31, 5'd31);
        drain();

        // order zero taken as two, invertible key, unused entries nonzero
        write_register(CFG_KEY_SIZE, 45'd0);
        write_register(CFG_KEY_ENTRIES,
                       pack_key(5'd3, 5'd3, 5'd31, 5'd2, 5'd5, 5'd17, 5'd9, 5'd30, 5'd31));
        queue_block(5'd7, 5'd8, 5'd31);
        queue_block(5'd0, 5'd25, 5'd12);
        queue_block(5'd30, 5'd29, 5'd3);
        drain();

        write_register(CFG_KEY_SIZE, 45'd3);
        write_register(CFG_KEY_ENTRIES,
                       pack_key(5'd6, 5'd24, 5'd1, 5'd13, 5'd16, 5'd10, 5'd20, 5'd17, 5'd15));
        queue_block(5'd0, 5'd2, 5'd19);
        queue_block(5'd25, 5'd25, 5'd25);
        queue_block(5'd31, 5'd26, 5'd0);
        drain();

        // order one taken as two, even determinant
        write_register(CFG_KEY_SIZE, 45'd1);
        write_register(CFG_KEY_ENTRIES,
                       pack_key(5'd2, 5'd4, 5'd9, 5'd6, 5'd8, 5'd9, 5'd9, 5'd9, 5'd9));
        queue_block(5'd5, 5'd5, 5'd5);
        queue_block(5'd25, 5'd0, 5'd31);
        drain();

        // index past the register list is dropped
        write_register(CFG_UNUSED, KEY_W'({$urandom, $urandom}));
        write_register(CFG_DIRECTION, 45'd0);
        write_register(CFG_KEY_SIZE, 45'd3);
        write_register(CFG_KEY_ENTRIES, '0);
        queue_block(5'd25, 5'd25, 5'd25);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode = $urandom_range(0, 3);
            key  = '0;
            case (mode)
                0: key = KEY_W'({$urandom, $urandom});
                1: for (int j = 0; j < 9; j++) key[5*j +: 5] = t_letter'($urandom_range(0, 25));
                2: for (int j = 0; j < 9; j++) key[5*j +: 5] = t_letter'($urandom_range(0, 12));
                default: key = $urandom_range(0, 1) ? {KEY_W{1'b1}} : '0;
            endcase
            pacing_on = (p % 4 != 3);
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_UNUSED, KEY_W'({$urandom, $urandom}));
            write_register(CFG_KEY_SIZE, KEY_W'($urandom_range(0, 3)));
            write_register(CFG_KEY_ENTRIES, key);
            write_register(CFG_DIRECTION, KEY_W'($urandom_range(0, 1)));
            for (int i = 0; i < PHASE_BLOCKS; i++)
                queue_block(rand_letter(), rand_letter(), rand_letter());
            drain();
        end

        repeat (16) @(posedge i_clk);
        if (error_count == 0 && expected_cipher.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/hcb_pkg.sv
hdl/hcb_in_if.sv
hdl/hcb_out_if.sv
hdl/hcb_cfg_if.sv
hdl/hcb_key_prep.sv
hdl/hcb_lane.sv
hdl/hcb_merge.sv
hdl/hill_cipher_block_unit.sv
hdl/hcb_checker.sv
sim/hill_cipher_block_unit_test.sv
